@@ sv/mlsf_pkg.sv @@
// shared widths, register codes, update kinds and types for the lag/slew filter
`timescale 1ns / 1ps
`default_nettype none

package mlsf_pkg;

   // default parameter values
   localparam int DEF_CHANNELS            = 8;
   localparam int DEF_ALPHA_FRACTION_BITS = 12;

   // field widths
   localparam int CHAN_W  = 3;
   localparam int RAW_W   = 16;
   localparam int TIME_W  = 32;
   localparam int RPM_W   = 24;
   localparam int KIND_W  = 3;
   localparam int MULT_W  = 8;
   localparam int CFG_W   = 16;
   localparam int CSR_IDX_W = 3;

   // largest channel number any parameter value allows, plus one bit of headroom
   localparam int CHAN_EXT_W = 7;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_MULT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LAG_TAU    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLEW       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RESTART    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_FLOOR = 3'd4;

   // register reset values
   localparam logic [MULT_W-1:0] RST_COUNT_MULT = 8'd1;
   localparam logic [CFG_W-1:0]  RST_LAG_TAU    = 16'd1000;
   localparam logic [CFG_W-1:0]  RST_SLEW       = 16'd1500;
   localparam logic [CFG_W-1:0]  RST_RESTART    = 16'd5000;
   localparam logic [CFG_W-1:0]  RST_ZERO_FLOOR = 16'd50;

   // slew limit: (slew * dt) / 1000 as a multiply by ceil(2^38 / 1000) and a shift,
   // exact for every 32-bit product
   localparam int SLEW_PROD_W    = 32;
   localparam int SLEW_RECIP_W   = 29;
   localparam int SLEW_DIV_SHIFT = 38;
   localparam int LIMIT_W        = 23;
   localparam int LIM_PROD_W     = SLEW_PROD_W + SLEW_RECIP_W;
   localparam logic [SLEW_RECIP_W-1:0] SLEW_DIV_RECIP = 29'd274877907;

   // divisor of the alpha division: tau + dt
   localparam int DIVISOR_W = CFG_W + 1;

   // update kinds reported with every result
   typedef enum logic [KIND_W-1:0] {
      KIND_ZERO      = 3'd0,
      KIND_RELOAD    = 3'd1,
      KIND_SAME_TIME = 3'd2,
      KIND_NO_CHANGE = 3'd3,
      KIND_STEP      = 3'd4
   } mlsf_kind_type;

   // one channel's stored state
   typedef struct packed {
      logic [RPM_W-1:0]  smoothed;
      logic [TIME_W-1:0] last_time;
   } mlsf_entry_type;

   // divider status towards the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } mlsf_div_status_type;

endpackage

`default_nettype wire

@@ sv/multichannel_lag_slew_filter_unit.sv @@
// Per-channel tachometer filter: scales each raw count, then snaps to zero, reloads or
// steps the channel's smoothed value toward it by a first-order lag with a slew limit,
// and returns one result for every sample. The state of all channels sits in one
// memory with a registered read, and items are handled one at a time. A sample that
// ends in a zero snap, reload, repeated timestamp or unchanged value passes through the
// load, classify and write states before rsp_tvalid rises; a filtered step also passes
// through the divide and step states, where the restoring divider forms alpha one
// quotient bit per cycle. A new sample is taken the cycle after the previous result is
// registered, while that result may still be waiting on rsp_tready. No clearing pass is
// needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module multichannel_lag_slew_filter_unit
   import mlsf_pkg::*;
#(
   parameter int CHANNELS            = DEF_CHANNELS,
   parameter int ALPHA_FRACTION_BITS = DEF_ALPHA_FRACTION_BITS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // sample channel
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [47:0]          req_tdata,   // raw_count[15:0], sample_time_ms[47:16]
   input  wire logic [CHAN_W-1:0]    req_tuser,   // fan_channel[2:0]
   // result channel
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [RPM_W-1:0]          rsp_tdata,   // filtered_rpm[23:0]
   output logic [5:0]                rsp_tuser,   // out_channel[2:0], update_kind[5:3]
   // register writes
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wr_data
);

   localparam int IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int ALPHA_W = ALPHA_FRACTION_BITS + 1;
   localparam int PROD_W  = RPM_W + ALPHA_W;
   localparam logic [CHAN_EXT_W-1:0] CHAN_COUNT = CHAN_EXT_W'(CHANNELS);
   localparam logic [ALPHA_W-1:0]    ALPHA_ONE  = {1'b1, {ALPHA_FRACTION_BITS{1'b0}}};
   localparam logic [PROD_W:0]       ROUND_UP   =
      {{(PROD_W + 1 - ALPHA_FRACTION_BITS){1'b0}}, {ALPHA_FRACTION_BITS{1'b1}}};

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_LOAD     = 6'b000010,
      ST_CLASSIFY = 6'b000100,
      ST_DIVIDE   = 6'b001000,
      ST_STEP     = 6'b010000,
      ST_WRITE    = 6'b100000
   } state_type;

   // configuration registers
   logic [MULT_W-1:0] mult_ff;
   logic [CFG_W-1:0]  tau_ff;
   logic [CFG_W-1:0]  slew_ff;
   logic [CFG_W-1:0]  gap_ff;
   logic [CFG_W-1:0]  floor_ff;

   // sequencer and item registers
   state_type               state_ff, state_in;
   logic [CHAN_W-1:0]       ch_ff, ch_in;
   logic [RAW_W-1:0]        raw_ff, raw_in;
   logic [TIME_W-1:0]       time_ff, time_in;
   logic [RPM_W-1:0]        scaled_ff, scaled_in;
   logic [TIME_W-1:0]       dt_ff, dt_in;
   logic [RPM_W-1:0]        mag_ff, mag_in;
   logic                    up_ff, up_in;
   logic [SLEW_PROD_W-1:0]  slew_prod_ff, slew_prod_in;
   logic [LIM_PROD_W-1:0]   lim_prod_ff, lim_prod_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [RPM_W-1:0]        new_val_ff, new_val_in;
   mlsf_kind_type           kind_ff, kind_in;
   logic                    wr_need_ff, wr_need_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CHAN_W-1:0]       rsp_ch_ff, rsp_ch_in;
   logic [RPM_W-1:0]        rsp_val_ff, rsp_val_in;
   mlsf_kind_type           rsp_kind_ff, rsp_kind_in;

   // memory and divider hookup
   logic                    req_fire;
   logic [CHAN_EXT_W-1:0]   req_ch_ext;
   logic [CHAN_EXT_W-1:0]   ch_ext;
   logic                    ch_in_range;
   logic                    mem_wr_en;
   mlsf_entry_type          mem_wr_entry;
   mlsf_entry_type          mem_rd_entry;
   logic                    mem_rd_seen;
   logic                    div_start;
   mlsf_div_status_type     div_stat;
   logic [ALPHA_W-1:0]      div_quo;

   // step arithmetic
   logic [RPM_W-1:0]        cur_val;
   logic [PROD_W:0]         rnd_sum;
   logic [RPM_W-1:0]        step_raw;
   logic [RPM_W-1:0]        step_min;
   logic [LIMIT_W-1:0]      lim_raw;
   logic [RPM_W-1:0]        lim_val;
   logic [RPM_W-1:0]        step_val;
   logic                    rsp_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_ch_ext = {{(CHAN_EXT_W - CHAN_W){1'b0}}, req_tuser};
   assign ch_ext     = {{(CHAN_EXT_W - CHAN_W){1'b0}}, ch_ff};
   assign ch_in_range = (ch_ext < CHAN_COUNT);
   assign cur_val    = mem_rd_entry.smoothed;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mult_ff  <= RST_COUNT_MULT;
         tau_ff   <= RST_LAG_TAU;
         slew_ff  <= RST_SLEW;
         gap_ff   <= RST_RESTART;
         floor_ff <= RST_ZERO_FLOOR;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_COUNT_MULT: mult_ff  <= csr_wr_data[MULT_W-1:0];
            CSR_LAG_TAU:    tau_ff   <= csr_wr_data;
            CSR_SLEW:       slew_ff  <= csr_wr_data;
            CSR_RESTART:    gap_ff   <= csr_wr_data;
            CSR_ZERO_FLOOR: floor_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // state memory, read at acceptance and written back at the end of the item
   mlsf_state_mem #(
      .DEPTH (CHANNELS),
      .IDX_W (IDX_W)
   ) u_state_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_fire),
      .rd_addr  (req_ch_ext[IDX_W-1:0]),
      .wr_en    (mem_wr_en),
      .wr_addr  (ch_ext[IDX_W-1:0]),
      .wr_entry (mem_wr_entry),
      .rd_entry (mem_rd_entry),
      .rd_seen  (mem_rd_seen)
   );

   // alpha divider
   mlsf_divider #(
      .FRAC_BITS (ALPHA_FRACTION_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dt       (dt_ff[CFG_W-1:0]),
      .tau      (tau_ff),
      .status   (div_stat),
      .quotient (div_quo)
   );

   // rounded, floored and slew-clamped step magnitude
   always_comb begin
      rnd_sum  = {1'b0, prod_ff} + (up_ff ? '0 : ROUND_UP);
      step_raw = rnd_sum[ALPHA_FRACTION_BITS +: RPM_W];
      step_min = (step_raw == '0) ? RPM_W'(1) : step_raw;
      lim_raw  = lim_prod_ff[SLEW_DIV_SHIFT +: LIMIT_W];
      lim_val  = (lim_raw == '0) ? RPM_W'(1) : {1'b0, lim_raw};
      step_val = (step_min > lim_val) ? lim_val : step_min;
   end

   // sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      raw_in       = raw_ff;
      time_in      = time_ff;
      scaled_in    = scaled_ff;
      dt_in        = dt_ff;
      mag_in       = mag_ff;
      up_in        = up_ff;
      slew_prod_in = slew_prod_ff;
      lim_prod_in  = lim_prod_ff;
      prod_in      = prod_ff;
      new_val_in   = new_val_ff;
      kind_in      = kind_ff;
      wr_need_in   = wr_need_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_ch_in    = rsp_ch_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_kind_in  = rsp_kind_ff;
      div_start    = 1'b0;
      mem_wr_en    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               ch_in    = req_tuser;
               raw_in   = req_tdata[RAW_W-1:0];
               time_in  = req_tdata[RAW_W +: TIME_W];
               state_in = ST_LOAD;
            end
         end
         // memory data arrives: scale and elapsed time
         ST_LOAD: begin
            scaled_in = {{(RPM_W - RAW_W){1'b0}}, raw_ff} *
                        {{(RPM_W - MULT_W){1'b0}}, mult_ff};
            dt_in     = time_ff - mem_rd_entry.last_time;
            state_in  = ST_CLASSIFY;
         end
         // pick the kind of update
         ST_CLASSIFY: begin
            up_in        = (scaled_ff > cur_val);
            mag_in       = (scaled_ff > cur_val) ? (scaled_ff - cur_val)
                                                 : (cur_val - scaled_ff);
            slew_prod_in = {{(SLEW_PROD_W - CFG_W){1'b0}}, slew_ff} *
                           {{(SLEW_PROD_W - CFG_W){1'b0}}, dt_ff[CFG_W-1:0]};
            state_in     = ST_WRITE;
            if (!ch_in_range) begin
               new_val_in = '0;
               kind_in    = KIND_SAME_TIME;
               wr_need_in = 1'b0;
            end else if (scaled_ff < {8'd0, floor_ff}) begin
               new_val_in = '0;
               kind_in    = KIND_ZERO;
               wr_need_in = 1'b1;
            end else if (!mem_rd_seen || (dt_ff > {16'd0, gap_ff})) begin
               new_val_in = scaled_ff;
               kind_in    = KIND_RELOAD;
               wr_need_in = 1'b1;
            end else if (dt_ff == '0) begin
               new_val_in = cur_val;
               kind_in    = KIND_SAME_TIME;
               wr_need_in = 1'b0;
            end else if (scaled_ff == cur_val) begin
               new_val_in = cur_val;
               kind_in    = KIND_NO_CHANGE;
               wr_need_in = 1'b1;
            end else begin
               kind_in    = KIND_STEP;
               wr_need_in = 1'b1;
               div_start  = 1'b1;
               state_in   = ST_DIVIDE;
            end
         end
         // alpha division; slew limit product formed alongside
         ST_DIVIDE: begin
            lim_prod_in = slew_prod_ff * SLEW_DIV_RECIP;
            if (div_stat.done) begin
               prod_in  = mag_ff * div_quo;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            new_val_in = up_ff ? (cur_val + step_val) : (cur_val - step_val);
            state_in   = ST_WRITE;
         end
         // write back and hand over the result once the output register is free
         ST_WRITE: begin
            if (rsp_free) begin
               mem_wr_en    = wr_need_ff;
               rsp_valid_in = 1'b1;
               rsp_ch_in    = ch_ff;
               rsp_val_in   = new_val_ff;
               rsp_kind_in  = kind_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign mem_wr_entry.smoothed  = new_val_ff;
   assign mem_wr_entry.last_time = time_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ch_ff        <= ch_in;
      raw_ff       <= raw_in;
      time_ff      <= time_in;
      scaled_ff    <= scaled_in;
      dt_ff        <= dt_in;
      mag_ff       <= mag_in;
      up_ff        <= up_in;
      slew_prod_ff <= slew_prod_in;
      lim_prod_ff  <= lim_prod_in;
      prod_ff      <= prod_in;
      new_val_ff   <= new_val_in;
      kind_ff      <= kind_in;
      wr_need_ff   <= wr_need_in;
      rsp_ch_ff    <= rsp_ch_in;
      rsp_val_ff   <= rsp_val_in;
      rsp_kind_ff  <= rsp_kind_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_val_ff;
   assign rsp_tuser  = {rsp_kind_ff, rsp_ch_ff};

   // divider only runs while the sequencer waits on it
   a_div_in_divide: assert property (@(posedge clock) disable iff (reset)
      (div_stat.busy || div_stat.done) |-> (state_ff == ST_DIVIDE))
      else $error("divider active outside the divide state");

   // alpha never exceeds one
   a_alpha_range: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (div_quo <= ALPHA_ONE))
      else $error("alpha above one");

   // a filtered step moves strictly toward the scaled value without overshoot
   a_step_bounded: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_WRITE) && (kind_ff == KIND_STEP)) |->
         (up_ff ? ((new_val_ff > cur_val) && (new_val_ff <= scaled_ff))
                : ((new_val_ff < cur_val) && (new_val_ff >= scaled_ff))))
      else $error("filter step outside old and scaled value");

   // a new result only appears out of the write-back state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_WRITE))
      else $error("result presented without write-back");

endmodule

`default_nettype wire

@@ sv/mlsf_state_mem.sv @@
// per-channel state memory with registered read and reset-cleared seen bits
`timescale 1ns / 1ps
`default_nettype none

module mlsf_state_mem
   import mlsf_pkg::*;
#(
   parameter int DEPTH = DEF_CHANNELS,
   parameter int IDX_W = 3
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           rd_en,
   input  wire logic [IDX_W-1:0] rd_addr,
   input  wire logic           wr_en,
   input  wire logic [IDX_W-1:0] wr_addr,
   input  wire mlsf_entry_type wr_entry,
   output mlsf_entry_type      rd_entry,
   output logic                rd_seen
);

   mlsf_entry_type   mem_ff [DEPTH];
   logic [DEPTH-1:0] seen_ff;
   mlsf_entry_type   rd_entry_ff;
   logic             rd_seen_ff;

   // seen bits: cleared by reset, set by any write
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else if (wr_en) begin
         seen_ff[wr_addr] <= 1'b1;
      end
   end

   // storage array, one write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_entry;
      end
   end

   // registered read; a never-written entry reads as zero
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_seen_ff  <= seen_ff[rd_addr];
         rd_entry_ff <= seen_ff[rd_addr] ? mem_ff[rd_addr] : '0;
      end
   end

   assign rd_entry = rd_entry_ff;
   assign rd_seen  = rd_seen_ff;

endmodule

`default_nettype wire

@@ sv/mlsf_divider.sv @@
// restoring divider for alpha = (dt << frac) / (tau + dt), one quotient bit a cycle
`timescale 1ns / 1ps
`default_nettype none

module mlsf_divider
   import mlsf_pkg::*;
#(
   parameter int FRAC_BITS = DEF_ALPHA_FRACTION_BITS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [CFG_W-1:0]     dt,
   input  wire logic [CFG_W-1:0]     tau,
   output mlsf_div_status_type       status,
   output logic [FRAC_BITS:0]        quotient
);

   localparam int Q_W   = FRAC_BITS + 1;
   localparam int CNT_W = $clog2(FRAC_BITS + 1);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(FRAC_BITS);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0] div_ff, div_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [Q_W-1:0]       low_ff, low_in;
   logic [Q_W-1:0]       quo_ff, quo_in;

   logic [DIVISOR_W:0]   rem_shift;
   logic [DIVISOR_W:0]   rem_diff;
   logic                 rem_ge;

   // one restoring step: the quotient never exceeds 2^frac, so the bits of dt
   // above bit 0 form the starting remainder and only frac+1 steps remain
   always_comb begin
      rem_shift = {rem_ff, low_ff[Q_W-1]};
      rem_ge    = (rem_shift >= {1'b0, div_ff});
      rem_diff  = rem_shift - {1'b0, div_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         div_in  = {1'b0, tau} + {1'b0, dt};
         rem_in  = {2'b00, dt[CFG_W-1:1]};
         low_in  = {dt[0], {FRAC_BITS{1'b0}}};
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = rem_ge ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
         low_in = {low_ff[Q_W-2:0], 1'b0};
         quo_in = {quo_ff[Q_W-2:0], rem_ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_CNT) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      div_ff <= div_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

`default_nettype wire
